// ===== sv/gtsd_pkg.sv =====
// Shared constants, types and tables of the GPS time string decoder.
`default_nettype none

package gtsd_pkg;

  // Frame geometry.
  localparam int unsigned FRAME_LEN = 55;
  localparam int unsigned PosW      = $clog2(FRAME_LEN + 1);
  localparam int unsigned AddrW     = $clog2(FRAME_LEN);

  // Widths of result fields, parsed time fields and intermediate sums.
  localparam int unsigned DropW  = 16;
  localparam int unsigned EpochW = 31;
  localparam int unsigned DaysW  = 15;
  localparam int unsigned TodW   = 17;
  localparam int unsigned FldW   = 14;

  // Special bytes.
  localparam logic [7:0] START_BYTE = 8'h24;
  localparam logic [7:0] END_BYTE   = 8'h0a;
  localparam logic [7:0] LOCK_BYTE  = 8'h31;
  localparam logic [7:0] DIGIT_LO   = 8'h30;
  localparam logic [7:0] DIGIT_HI   = 8'h39;

  // Positions of the time fields inside a frame.
  localparam int unsigned POS_HOUR = 10;
  localparam int unsigned POS_MIN  = 12;
  localparam int unsigned POS_SEC  = 14;
  localparam int unsigned POS_DAY  = 17;
  localparam int unsigned POS_MON  = 20;
  localparam int unsigned POS_YEAR = 23;
  localparam int unsigned POS_LOCK = 28;

  // Calendar limits.
  localparam logic [FldW-1:0] YEAR_MIN   = 14'd1997;
  localparam logic [FldW-1:0] YEAR_MAX   = 14'd2037;
  localparam logic [FldW-1:0] EPOCH_YEAR = 14'd1970;
  localparam logic [EpochW-1:0] EPOCH_MAX = 31'd2145916799;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_HOUR  = 3'd1,
    ST_BAD_MIN   = 3'd2,
    ST_BAD_SEC   = 3'd3,
    ST_BAD_DAY   = 3'd4,
    ST_BAD_MONTH = 3'd5,
    ST_BAD_YEAR  = 3'd6
  } status_e;

  // Request from the framer to the decoder when a frame closes.
  typedef struct packed {
    logic             start;
    logic [DropW-1:0] dropped;
  } close_req_t;

  // Finished result offered by the decoder.
  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [EpochW-1:0] epoch;
    logic              locked;
    logic [DropW-1:0]  dropped;
  } fix_res_t;

  // Days in the year before the first of a month (1..12).
  function automatic logic [8:0] days_before_month(input logic [3:0] mo);
    logic [8:0] d;
    d = 9'd0;
    case (mo)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== sv/gtsd_rx_if.sv =====
// Byte channel into the decoder.
`default_nettype none

interface gtsd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/gtsd_res_if.sv =====
// Result channel out of the decoder.
`default_nettype none

interface gtsd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [30:0] epoch_seconds;
  logic        gps_locked;
  logic [15:0] dropped_bytes;

  modport source (output valid, output status, output epoch_seconds,
                  output gps_locked, output dropped_bytes, input ready);
  modport sink (input valid, input status, input epoch_seconds,
                input gps_locked, input dropped_bytes, output ready);
endinterface

`default_nettype wire

// ===== sv/gtsd_framer.sv =====
// Frame builder: byte position, dropped count and the frame memory.
`default_nettype none

module gtsd_framer import gtsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o,
  output close_req_t       start_o
);

  logic [7:0]       mem_q [FRAME_LEN];
  logic [7:0]       rd_data_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [DropW-1:0] drop_q, drop_d;
  logic [PosW-1:0]  add_amt;
  logic             add_en;
  logic             wr_en;
  logic             close;
  logic             is_start;
  logic             is_end;
  logic [DropW:0]   drop_sum;

  assign is_start = (rx_byte_i == START_BYTE);
  assign is_end   = (rx_byte_i == END_BYTE);

  // Framing decision for an accepted byte.
  always_comb begin
    pos_d   = pos_q;
    add_amt = '0;
    add_en  = 1'b0;
    wr_en   = 1'b0;
    close   = 1'b0;
    if (accept_i) begin
      if (pos_q == '0 && !is_start) begin
        add_en  = 1'b1;
        add_amt = PosW'(1);
      end else if (pos_q != '0 && is_start) begin
        add_en  = 1'b1;
        add_amt = pos_q;
        pos_d   = PosW'(1);
      end else if (pos_q >= PosW'(FRAME_LEN)) begin
        if (is_end) begin
          close = 1'b1;
          pos_d = '0;
        end else begin
          add_en  = 1'b1;
          add_amt = pos_q;
          pos_d   = PosW'(1);
        end
      end else begin
        wr_en = 1'b1;
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  // Saturating dropped count, cleared when its value leaves with a frame.
  assign drop_sum = {1'b0, drop_q} + (DropW + 1)'(add_amt);

  always_comb begin
    drop_d = drop_q;
    if (close) begin
      drop_d = '0;
    end else if (add_en) begin
      drop_d = drop_sum[DropW] ? '1 : drop_sum[DropW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      drop_q <= '0;
    end else begin
      pos_q  <= pos_d;
      drop_q <= drop_d;
    end
  end

  // Frame memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[pos_q[AddrW-1:0]] <= rx_byte_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o       = rd_data_q;
  assign start_o.start   = close;
  assign start_o.dropped = drop_q;

endmodule

`default_nettype wire

// ===== sv/gtsd_decoder.sv =====
// Frame decoder: reads the time fields from memory, checks them, builds epoch seconds.
`default_nettype none

module gtsd_decoder import gtsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  close_req_t       start_i,
  output logic             busy_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  logic [7:0]       rd_data_i,
  output fix_res_t         res_o,
  input  logic             ack_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_CHECK,
    S_YEARS,
    S_MONTHS,
    S_SCALE,
    S_SUM,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    FLD_HOUR  = 3'd0,
    FLD_MIN   = 3'd1,
    FLD_SEC   = 3'd2,
    FLD_DAY   = 3'd3,
    FLD_MONTH = 3'd4,
    FLD_YEAR  = 3'd5
  } fld_e;

  localparam int unsigned NumFld = 6;

  state_e            state_q, state_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic              dat_vld_q;
  logic [AddrW-1:0]  dat_addr_q;

  logic [FldW-1:0]   fld_val_q [NumFld];
  logic              fld_bad_q [NumFld];
  logic              lock_q;
  status_e           status_q, status_d;
  logic [DaysW-1:0]  days_q;
  logic [EpochW-1:0] prod_q;
  logic [TodW-1:0]   tod_q;
  logic [EpochW-1:0] epoch_q;
  logic              locked_q;
  logic [DropW-1:0]  drop_q;

  logic              fld_hit;
  logic              fld_first;
  fld_e              fld_idx;
  logic              lock_hit;
  logic              is_dig;
  logic [3:0]        dig_val;
  logic [FldW+3:0]   acc_sum;
  logic [FldW-1:0]   v_hr, v_mn, v_sc, v_da, v_mo, v_yr;
  logic [FldW-1:0]   yr_off, yr_q4;
  logic              leap;
  logic              ok;

  assign v_hr = fld_val_q[FLD_HOUR];
  assign v_mn = fld_val_q[FLD_MIN];
  assign v_sc = fld_val_q[FLD_SEC];
  assign v_da = fld_val_q[FLD_DAY];
  assign v_mo = fld_val_q[FLD_MONTH];
  assign v_yr = fld_val_q[FLD_YEAR];

  // Map the address of returning read data onto its field.
  always_comb begin
    fld_hit   = 1'b0;
    fld_first = 1'b0;
    fld_idx   = FLD_HOUR;
    lock_hit  = 1'b0;
    unique case (dat_addr_q) inside
      AddrW'(POS_HOUR):     begin fld_hit = 1'b1; fld_first = 1'b1; fld_idx = FLD_HOUR; end
      AddrW'(POS_HOUR + 1): begin fld_hit = 1'b1; fld_idx = FLD_HOUR; end
      AddrW'(POS_MIN):      begin fld_hit = 1'b1; fld_first = 1'b1; fld_idx = FLD_MIN; end
      AddrW'(POS_MIN + 1):  begin fld_hit = 1'b1; fld_idx = FLD_MIN; end
      AddrW'(POS_SEC):      begin fld_hit = 1'b1; fld_first = 1'b1; fld_idx = FLD_SEC; end
      AddrW'(POS_SEC + 1):  begin fld_hit = 1'b1; fld_idx = FLD_SEC; end
      AddrW'(POS_DAY):      begin fld_hit = 1'b1; fld_first = 1'b1; fld_idx = FLD_DAY; end
      AddrW'(POS_DAY + 1):  begin fld_hit = 1'b1; fld_idx = FLD_DAY; end
      AddrW'(POS_MON):      begin fld_hit = 1'b1; fld_first = 1'b1; fld_idx = FLD_MONTH; end
      AddrW'(POS_MON + 1):  begin fld_hit = 1'b1; fld_idx = FLD_MONTH; end
      AddrW'(POS_YEAR):     begin fld_hit = 1'b1; fld_first = 1'b1; fld_idx = FLD_YEAR; end
      [AddrW'(POS_YEAR + 1):AddrW'(POS_YEAR + 3)]: begin
        fld_hit = 1'b1;
        fld_idx = FLD_YEAR;
      end
      AddrW'(POS_LOCK):     lock_hit = 1'b1;
      default: ;
    endcase
  end

  // One decimal digit per cycle into the selected field.
  assign is_dig  = (rd_data_i >= DIGIT_LO) && (rd_data_i <= DIGIT_HI);
  assign dig_val = rd_data_i[3:0];
  assign acc_sum = (FldW + 4)'(fld_val_q[fld_idx]) * (FldW + 4)'(10)
                 + (FldW + 4)'(dig_val);

  // Range checks in field order; the first failure wins.
  always_comb begin
    if (fld_bad_q[FLD_HOUR] || v_hr > 14'd23) begin
      status_d = ST_BAD_HOUR;
    end else if (fld_bad_q[FLD_MIN] || v_mn > 14'd59) begin
      status_d = ST_BAD_MIN;
    end else if (fld_bad_q[FLD_SEC] || v_sc > 14'd59) begin
      status_d = ST_BAD_SEC;
    end else if (fld_bad_q[FLD_DAY] || v_da < 14'd1 || v_da > 14'd31) begin
      status_d = ST_BAD_DAY;
    end else if (fld_bad_q[FLD_MONTH] || v_mo < 14'd1 || v_mo > 14'd12) begin
      status_d = ST_BAD_MONTH;
    end else if (fld_bad_q[FLD_YEAR] || v_yr < YEAR_MIN || v_yr > YEAR_MAX) begin
      status_d = ST_BAD_YEAR;
    end else begin
      status_d = ST_OK;
    end
  end

  // Leap days before the year count 1972 onward: (year - 1969) / 4.
  assign ok     = (status_q == ST_OK);
  assign yr_off = v_yr - EPOCH_YEAR;
  assign yr_q4  = (v_yr - EPOCH_YEAR + 14'd1) >> 2;
  assign leap   = (v_mo > 14'd2) && (v_yr[1:0] == 2'b00);

  // Sequencer: read addresses, then the arithmetic steps.
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i.start) begin
          state_d = S_READ;
          addr_d  = AddrW'(POS_HOUR);
        end
      end
      S_READ: begin
        addr_d = addr_q + AddrW'(1);
        if (addr_q == AddrW'(POS_LOCK)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN:  state_d = S_CHECK;
      S_CHECK:  state_d = S_YEARS;
      S_YEARS:  state_d = S_MONTHS;
      S_MONTHS: state_d = S_SCALE;
      S_SCALE:  state_d = S_SUM;
      S_SUM:    state_d = S_DONE;
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      addr_q     <= '0;
      dat_vld_q  <= 1'b0;
      dat_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      addr_q     <= addr_d;
      dat_vld_q  <= (state_q == S_READ);
      dat_addr_q <= addr_q;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i.start) begin
      drop_q <= start_i.dropped;
    end
    if (dat_vld_q && fld_hit) begin
      fld_val_q[fld_idx] <= fld_first ? FldW'(dig_val) : acc_sum[FldW-1:0];
      fld_bad_q[fld_idx] <= fld_first ? !is_dig : (fld_bad_q[fld_idx] || !is_dig);
    end
    if (dat_vld_q && lock_hit) begin
      lock_q <= (rd_data_i == LOCK_BYTE);
    end
    if (state_q == S_CHECK) begin
      status_q <= status_d;
    end
    if (state_q == S_YEARS) begin
      days_q <= DaysW'(yr_off[6:0]) * DaysW'(365) + DaysW'(yr_q4[4:0]);
    end
    if (state_q == S_MONTHS) begin
      days_q <= days_q + DaysW'(days_before_month(v_mo[3:0]))
              + DaysW'(v_da[4:0]) - DaysW'(1) + DaysW'(leap);
    end
    if (state_q == S_SCALE) begin
      prod_q <= EpochW'(days_q) * EpochW'(86400);
      tod_q  <= TodW'(v_hr[4:0]) * TodW'(3600) + TodW'(v_mn[5:0]) * TodW'(60)
              + TodW'(v_sc[5:0]);
    end
    if (state_q == S_SUM) begin
      epoch_q  <= ok ? (prod_q + EpochW'(tod_q)) : '0;
      locked_q <= ok && lock_q;
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign rd_addr_o     = addr_q;
  assign res_o.valid   = (state_q == S_DONE);
  assign res_o.status  = status_q;
  assign res_o.epoch   = epoch_q;
  assign res_o.locked  = locked_q;
  assign res_o.dropped = drop_q;

endmodule

`default_nettype wire

// ===== sv/gps_time_string_decoder.sv =====
// Top level of the GPS time string decoder: framer, decoder and output register.
//
// Channels: rx_i takes one received byte per request (valid/ready); res_o
// gives one result per closed frame: status, epoch seconds, lock flag and
// the count of bytes dropped since the previous result.
// An ordinary byte is taken while the decoder is idle: it updates the
// frame position and dropped count and is written into the frame memory.
// The line feed that closes a frame starts the decoder, which reads the
// nineteen frame bytes from the hour field up to the lock byte through
// the memory's single registered read port, one per cycle; after a drain
// state it runs the range checks and the epoch arithmetic in its check,
// years, months, scale and sum states. rx_i is held off until the result
// is loaded into the output register.
// The output register lets the next frame's bytes enter while a result
// waits. If the receiver stalls and a second frame closes, the finished
// result waits in the decoder and rx_i stays low until it moves on.
// Reset clears the frame position, the dropped count and all valid state;
// the frame memory is not cleared, since every byte decoded is written
// first.
`default_nettype none

module gps_time_string_decoder import gtsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  gtsd_rx_if.sink     rx_i,
  gtsd_res_if.source  res_o
);

  logic             accept;
  logic             busy;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;
  close_req_t       start;
  fix_res_t         fix_res;
  logic             load;

  logic              out_vld_q;
  logic [2:0]        status_q;
  logic [EpochW-1:0] epoch_q;
  logic              locked_q;
  logic [DropW-1:0]  drop_q;

  assign rx_i.ready = !busy;
  assign accept     = rx_i.valid && !busy;

  gtsd_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_i.rx_byte),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .start_o   (start)
  );

  gtsd_decoder u_decoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_o    (busy),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .res_o     (fix_res),
    .ack_i     (load)
  );

  // Output register: loads when empty or being emptied.
  assign load = fix_res.valid && (!out_vld_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= fix_res.status;
      epoch_q  <= fix_res.epoch;
      locked_q <= fix_res.locked;
      drop_q   <= fix_res.dropped;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.status        = status_q;
  assign res_o.epoch_seconds = epoch_q;
  assign res_o.gps_locked    = locked_q;
  assign res_o.dropped_bytes = drop_q;

  // A closing line feed puts the decoder to work in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start.start |=> busy)
    else $error("decoder did not start after frame close");

  // A failed decode carries neither time nor lock.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status != ST_OK) |->
      (res_o.epoch_seconds == '0 && !res_o.gps_locked))
    else $error("failed decode carries time or lock");

  // Status codes stay within the defined set and good times in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.status <= ST_BAD_YEAR && res_o.epoch_seconds <= EPOCH_MAX))
    else $error("result status or epoch out of range");

endmodule

`default_nettype wire
